@@ design/assert_macros.svh @@
// Assertion macros used by the RTL core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ design/rcfd_pkg.sv @@
// Types, constants and latch helper for the remote-control frame decoder
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam int HOLD_RIGHT = 0;
    localparam int HOLD_W     = 1;
    localparam int HOLD_S     = 2;
    localparam int HOLD_A     = 3;
    localparam int HOLD_SHIFT = 4;
    localparam int HOLD_Q     = 5;
    localparam int HOLD_E     = 6;
    localparam int HOLD_COUNT = 7;
    localparam int KEY_COUNT  = 6;

    // per output key bit: latch index, source bit in byte 14, long limit
    localparam int   KEY_LATCH [KEY_COUNT] = '{HOLD_W, HOLD_S, HOLD_A, HOLD_SHIFT, HOLD_Q, HOLD_E};
    localparam int   KEY_SRC   [KEY_COUNT] = '{0, 1, 2, 4, 6, 7};
    localparam logic KEY_LONG  [KEY_COUNT] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    localparam logic [7:0] HOLD_LONG_RST  = 8'd50;
    localparam logic [7:0] HOLD_SHORT_RST = 8'd30;
    localparam logic [7:0] RIGHT_ON       = 8'h01;
    localparam logic [7:0] HOLD_CNT_MAX   = 8'hFF;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    localparam logic CFG_HOLD_LONG  = 1'b0;
    localparam logic CFG_HOLD_SHORT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        stick0;
        logic [10:0]        stick1;
        logic [10:0]        stick2;
        logic [10:0]        stick3;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [5:0]         held_keys;
        logic [15:0]        wheel;
        logic               frame_ok;
    } t_out_item;

    typedef struct packed {
        logic       lat;
        logic [7:0] cnt;
        logic       follow;
    } t_latch_next;

    function automatic t_latch_next latch_step(logic lat, logic [7:0] cnt,
                                               logic is_one, logic [7:0] limit);
        t_latch_next r;
        logic        l1;
        logic [7:0]  c1;
        l1 = lat | is_one;
        c1 = (l1 && cnt != HOLD_CNT_MAX) ? cnt + 8'd1 : cnt;
        if (c1 > limit) begin
            l1 = 1'b0;
            c1 = 8'd0;
        end
        r.lat    = l1;
        r.cnt    = c1;
        r.follow = !lat;
        return r;
    endfunction

endpackage

@@ design/rcfd_in_if.sv @@
// Input item channel of the frame decoder
interface rcfd_in_if;
    logic               valid;
    logic               ready;
    rcfd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/rcfd_out_if.sv @@
// Result item channel of the frame decoder
interface rcfd_out_if;
    logic                valid;
    logic                ready;
    rcfd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/rc_frame_decoder_with_key_hold_core.sv @@
// Remote-control frame decoder with hold latches on right button and keys
// An idle item is held in the input register; its result is then written into the output register.
// Throughput: one item per cycle; an idle item waits only while an untaken result is held.
// Data bytes produce no result; each idle item produces exactly one.
// Reset clears count, good frame, latches, counters and held values; limits return to 50 and 30.
// The assembly buffer is not cleared; only bytes written in the current frame are read.
`include "assert_macros.svh"
module rc_frame_decoder_with_key_hold_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcfd_in_if.sink              i_in,
    rcfd_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata
);

    logic                        r_in_valid;
    rcfd_pkg::t_in_item          r_in;
    logic [rcfd_pkg::CNT_W-1:0]  r_count;
    logic [7:0]                  r_asm  [rcfd_pkg::FRAME_BYTES];
    logic [7:0]                  r_good [rcfd_pkg::FRAME_BYTES];
    logic [7:0]                  n_good [rcfd_pkg::FRAME_BYTES];
    logic                        r_hold_lat [rcfd_pkg::HOLD_COUNT];
    logic [7:0]                  r_hold_cnt [rcfd_pkg::HOLD_COUNT];
    logic                        n_hold_lat [rcfd_pkg::HOLD_COUNT];
    logic [7:0]                  n_hold_cnt [rcfd_pkg::HOLD_COUNT];
    logic [7:0]                  r_held_right;
    logic [7:0]                  n_held_right;
    logic [5:0]                  r_held_keys;
    logic [5:0]                  n_held_keys;
    logic [7:0]                  r_hold_long;
    logic [7:0]                  r_hold_short;
    logic                        r_out_valid;
    rcfd_pkg::t_out_item         r_out;
    rcfd_pkg::t_out_item         n_out;

    logic out_free;
    logic proc_go;
    logic is_idle;
    logic frame_ok;
    rcfd_pkg::t_latch_next lat_nx [rcfd_pkg::HOLD_COUNT];

    assign out_free   = !r_out_valid || o_out.ready;
    assign is_idle    = (r_in.cmd == rcfd_pkg::CMD_IDLE);
    assign proc_go    = r_in_valid && (!is_idle || out_free);
    assign i_in.ready = !r_in_valid || proc_go;
    assign frame_ok   = (r_count == rcfd_pkg::FRAME_CNT);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) begin
            n_good[i] = frame_ok ? r_asm[i] : r_good[i];
        end
        n_held_right = r_held_right;
        n_held_keys  = r_held_keys;
        lat_nx[rcfd_pkg::HOLD_RIGHT] = rcfd_pkg::latch_step(
            r_hold_lat[rcfd_pkg::HOLD_RIGHT], r_hold_cnt[rcfd_pkg::HOLD_RIGHT],
            r_asm[13] == rcfd_pkg::RIGHT_ON, r_hold_long);
        if (lat_nx[rcfd_pkg::HOLD_RIGHT].follow && frame_ok) begin
            n_held_right = r_asm[13];
        end
        for (int k = 0; k < rcfd_pkg::KEY_COUNT; k++) begin
            lat_nx[rcfd_pkg::KEY_LATCH[k]] = rcfd_pkg::latch_step(
                r_hold_lat[rcfd_pkg::KEY_LATCH[k]], r_hold_cnt[rcfd_pkg::KEY_LATCH[k]],
                r_asm[14][rcfd_pkg::KEY_SRC[k]],
                rcfd_pkg::KEY_LONG[k] ? r_hold_long : r_hold_short);
            if (lat_nx[rcfd_pkg::KEY_LATCH[k]].follow && frame_ok) begin
                n_held_keys[k] = r_asm[14][rcfd_pkg::KEY_SRC[k]];
            end
        end
        for (int h = 0; h < rcfd_pkg::HOLD_COUNT; h++) begin
            n_hold_lat[h] = frame_ok ? lat_nx[h].lat : r_hold_lat[h];
            n_hold_cnt[h] = frame_ok ? lat_nx[h].cnt : r_hold_cnt[h];
        end

        n_out.stick0        = {n_good[1][2:0], n_good[0]};
        n_out.stick1        = {n_good[2][5:0], n_good[1][7:3]};
        n_out.stick2        = {n_good[4][0], n_good[3], n_good[2][7:6]};
        n_out.stick3        = {n_good[5][3:0], n_good[4][7:1]};
        n_out.switches      = n_good[5][7:4];
        n_out.mouse_x       = {n_good[7], n_good[6]};
        n_out.mouse_y       = {n_good[9], n_good[8]};
        n_out.mouse_z       = {n_good[11], n_good[10]};
        n_out.mouse_buttons = {n_held_right, n_good[12]};
        n_out.held_keys     = n_held_keys;
        n_out.wheel         = {n_good[17], n_good[16]};
        n_out.frame_ok      = frame_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in <= i_in.data;
        end
        if (proc_go && !is_idle && r_count < rcfd_pkg::FRAME_CNT) begin
            r_asm[r_count[rcfd_pkg::IDX_W-1:0]] <= r_in.rx_byte;
        end
        if (proc_go && is_idle) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_held_right <= '0;
            r_held_keys  <= '0;
            r_hold_long  <= rcfd_pkg::HOLD_LONG_RST;
            r_hold_short <= rcfd_pkg::HOLD_SHORT_RST;
            for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) begin
                r_good[i] <= '0;
            end
            for (int h = 0; h < rcfd_pkg::HOLD_COUNT; h++) begin
                r_hold_lat[h] <= 1'b0;
                r_hold_cnt[h] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc_go && is_idle) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go) begin
                if (is_idle) begin
                    r_count      <= '0;
                    r_good       <= n_good;
                    r_hold_lat   <= n_hold_lat;
                    r_hold_cnt   <= n_hold_cnt;
                    r_held_right <= n_held_right;
                    r_held_keys  <= n_held_keys;
                end else if (r_count != rcfd_pkg::CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rcfd_pkg::CFG_HOLD_LONG:  r_hold_long  <= i_cfg_wdata;
                    rcfd_pkg::CFG_HOLD_SHORT: r_hold_short <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    `ASSERT_CLK(a_idle_clears_count, i_clk, i_rst_n, (proc_go && is_idle) |=> (r_count == '0))
    `ASSERT_CLK(a_idle_gives_result, i_clk, i_rst_n, (proc_go && is_idle) |=> r_out_valid)
    `ASSERT_CLK(a_stall_blocks_idle, i_clk, i_rst_n, (r_in_valid && is_idle && !out_free) |-> !i_in.ready)

    for (genvar g = 0; g < rcfd_pkg::HOLD_COUNT; g++) begin : g_hold_chk
        `ASSERT_CLK(a_cnt_only_latched, i_clk, i_rst_n, (r_hold_cnt[g] != 8'd0) |-> r_hold_lat[g])
    end

endmodule

@@ verif/rc_frame_decoder_with_key_hold_core_test.sv @@
// Self-checking testbench for the remote-control frame decoder with key hold latches
module rc_frame_decoder_with_key_hold_core_test;
    import rcfd_pkg::*;

    localparam int PHASES           = 8;
    localparam int FRAMES_PER_PHASE = 7;
    localparam int PRESSURE_PHASE   = 4;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 6;

    localparam int LONG_LIMITS  [PHASES] = '{50, 0, 255, 3, 254, 1, 9, 2};
    localparam int SHORT_LIMITS [PHASES] = '{30, 0, 255, 1, 254, 5, 0, 4};
    localparam int SEND_IDLE    [PHASES] = '{0, 52, 0, 14, 0, 52, 0, 14};
    localparam int RECV_STALL   [PHASES] = '{0, 0, 52, 14, 0, 0, 52, 14};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_wdata;

    rcfd_in_if  in_ch ();
    rcfd_out_if out_ch ();

    rc_frame_decoder_with_key_hold_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // decoder state as seen from outside
    logic [4:0] rx_count;
    logic [7:0] rx_bytes [FRAME_BYTES];
    logic [7:0] last_frame [FRAME_BYTES];
    bit         hold_on [HOLD_COUNT];
    logic [7:0] hold_frames [HOLD_COUNT];
    logic [7:0] right_held;
    logic [5:0] keys_held;
    logic [7:0] limit_long;
    logic [7:0] limit_short;

    t_in_item  rx_events [$];
    t_out_item decoded_frames [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    bit hold_off_req   = 1'b0;

    int good_frames     = 0;
    int results_checked = 0;
    int mismatches      = 0;

    always #5 clk = ~clk;

    function automatic void reset_decoder_model();
        rx_count = '0;
        right_held = '0;
        keys_held = '0;
        limit_long = HOLD_LONG_RST;
        limit_short = HOLD_SHORT_RST;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            rx_bytes[k] = '0;
            last_frame[k] = '0;
        end
        for (int k = 0; k < HOLD_COUNT; k++) begin
            hold_on[k] = 1'b0;
            hold_frames[k] = '0;
        end
    endfunction

    function automatic bit advance_latch(int idx, bit is_one, logic [7:0] limit);
        bit was_clear;
        was_clear = !hold_on[idx];
        if (was_clear && is_one) hold_on[idx] = 1'b1;
        if (hold_on[idx] && hold_frames[idx] != HOLD_CNT_MAX)
            hold_frames[idx] = hold_frames[idx] + 8'd1;
        if (hold_frames[idx] > limit) begin
            hold_on[idx] = 1'b0;
            hold_frames[idx] = '0;
        end
        return was_clear;
    endfunction

    function automatic void update_key(int idx, int src, int dst, logic [7:0] limit);
        bit pressed;
        pressed = last_frame[14][src];
        if (advance_latch(idx, pressed, limit)) keys_held[dst] = pressed;
    endfunction

    function automatic void decode_rx_event(t_in_item ev);
        t_out_item  r;
        bit         good;
        logic [7:0] f [FRAME_BYTES];
        if (ev.cmd == CMD_BYTE) begin
            if (rx_count < FRAME_BYTES) rx_bytes[rx_count] = ev.rx_byte;
            if (rx_count != CNT_MAX) rx_count = rx_count + 5'd1;
            return;
        end
        good = (rx_count == FRAME_BYTES);
        rx_count = '0;
        if (good) begin
            last_frame = rx_bytes;
            good_frames++;
            if (advance_latch(HOLD_RIGHT, last_frame[13] == RIGHT_ON, limit_long))
                right_held = last_frame[13];
            update_key(HOLD_SHIFT, 4, 3, limit_long);
            update_key(HOLD_S, 1, 1, limit_short);
            update_key(HOLD_A, 2, 2, limit_short);
            update_key(HOLD_Q, 6, 4, limit_short);
            update_key(HOLD_W, 0, 0, limit_short);
            update_key(HOLD_E, 7, 5, limit_short);
        end
        f = last_frame;
        r.stick0        = 11'({f[1], f[0]});
        r.stick1        = 11'({f[2], f[1]} >> 3);
        r.stick2        = 11'({f[4], f[3], f[2]} >> 6);
        r.stick3        = 11'({f[5], f[4]} >> 1);
        r.switches      = {f[5][7:6], f[5][5:4]};
        r.mouse_x       = {f[7], f[6]};
        r.mouse_y       = {f[9], f[8]};
        r.mouse_z       = {f[11], f[10]};
        r.mouse_buttons = {right_held, f[12]};
        r.held_keys     = keys_held;
        r.wheel         = {f[17], f[16]};
        r.frame_ok      = good;
        decoded_frames.push_back(r);
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want_v,
                                          logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (decoded_frames.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        want = decoded_frames.pop_front();
        results_checked++;
        compare_field("stick0", want.stick0, got.stick0);
        compare_field("stick1", want.stick1, got.stick1);
        compare_field("stick2", want.stick2, got.stick2);
        compare_field("stick3", want.stick3, got.stick3);
        compare_field("switches", want.switches, got.switches);
        compare_field("mouse_x", want.mouse_x, got.mouse_x);
        compare_field("mouse_y", want.mouse_y, got.mouse_y);
        compare_field("mouse_z", want.mouse_z, got.mouse_z);
        compare_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
        compare_field("held_keys", want.held_keys, got.held_keys);
        compare_field("wheel", want.wheel, got.wheel);
        compare_field("frame_ok", want.frame_ok, got.frame_ok);
    endfunction

    // fill < 0 gives random bytes, with the button and key bytes biased
    function automatic void queue_frame(int len, int fill);
        t_in_item ev;
        for (int k = 0; k < len; k++) begin
            ev.cmd = CMD_BYTE;
            ev.rx_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (fill < 0 && k == 13) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: ev.rx_byte = RIGHT_ON;
                    4, 5:       ev.rx_byte = 8'h00;
                    default: ;
                endcase
            end
            if (fill < 0 && k == 14) begin
                case ($urandom_range(3))
                    0:       ev.rx_byte = 8'h00;
                    1:       ev.rx_byte = 8'(1 << $urandom_range(7));
                    default: ;
                endcase
            end
            rx_events.push_back(ev);
        end
        ev.cmd = CMD_IDLE;
        ev.rx_byte = 8'($urandom);
        rx_events.push_back(ev);
    endfunction

    task automatic wait_drained();
        while (rx_events.size() != 0 || in_ch.valid || decoded_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(logic idx, logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HOLD_LONG) limit_long = value;
        else limit_short = value;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) decode_rx_event(in_ch.data);
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered item
            end else if (rx_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= rx_events.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (hold_off_req) begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_req  <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
            if (hold_off_left != 0) out_ch.ready <= 1'b0;
            else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int frame_len;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_HOLD_LONG;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        reset_decoder_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_frame(0, -1);
        queue_frame(FRAME_BYTES, 8'hFF);
        queue_frame(0, -1);
        queue_frame(2, 8'h00);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                write_limit(CFG_HOLD_LONG, 8'(LONG_LIMITS[p]));
                write_limit(CFG_HOLD_SHORT, 8'(SHORT_LIMITS[p]));
                @(negedge clk);
            end
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == PRESSURE_PHASE) begin
                hold_off_req = 1'b1;
                repeat (40) queue_frame(0, -1);
            end
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                case ($urandom_range(19))
                    0, 1:    frame_len = $urandom_range(FRAME_BYTES - 1);
                    2, 3:    frame_len = $urandom_range(FRAME_BYTES + 7, FRAME_BYTES + 1);
                    4:       frame_len = $urandom_range(40, 30);
                    default: frame_len = FRAME_BYTES;
                endcase
                queue_frame(frame_len, -1);
            end
            wait_drained();
        end

        $display("Checked %0d results, %0d from full frames, %0d mismatches.",
                 results_checked, good_frames, mismatches);
        $display("Hold limits 0 to 255, short, long and empty frames, four idle mixes, long stall.");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/rcfd_pkg.sv
design/rcfd_in_if.sv
design/rcfd_out_if.sv
design/rc_frame_decoder_with_key_hold_core.sv
verif/rc_frame_decoder_with_key_hold_core_test.sv
